### rtl/core/versatile_interface_adapter_top_assert.svh
// Assertion macros shared by the interface adapter RTL.
`ifndef VERSATILE_INTERFACE_ADAPTER_TOP_ASSERT_SVH
`define VERSATILE_INTERFACE_ADAPTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interface adapter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interface adapter assertion failed");

`endif

### rtl/core/via_pkg.sv
// Package with command codes, register map and flag masks of the interface adapter.
`timescale 1ns / 1ps
package via_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_CA1   = 2'd3;

  localparam logic [3:0] REG_ORB    = 4'd0;
  localparam logic [3:0] REG_ORA    = 4'd1;
  localparam logic [3:0] REG_DDRB   = 4'd2;
  localparam logic [3:0] REG_DDRA   = 4'd3;
  localparam logic [3:0] REG_T1CL   = 4'd4;
  localparam logic [3:0] REG_T1CH   = 4'd5;
  localparam logic [3:0] REG_T1LL   = 4'd6;
  localparam logic [3:0] REG_T1LH   = 4'd7;
  localparam logic [3:0] REG_T2CL   = 4'd8;
  localparam logic [3:0] REG_T2CH   = 4'd9;
  localparam logic [3:0] REG_SR     = 4'd10;
  localparam logic [3:0] REG_ACR    = 4'd11;
  localparam logic [3:0] REG_PCR    = 4'd12;
  localparam logic [3:0] REG_IFR    = 4'd13;
  localparam logic [3:0] REG_IER    = 4'd14;
  localparam logic [3:0] REG_ORA_NH = 4'd15;

  localparam logic [6:0] FLAG_PORTA = 7'h03;
  localparam logic [6:0] FLAG_CA1   = 7'h02;
  localparam logic [6:0] FLAG_T2    = 7'h20;
  localparam logic [6:0] FLAG_T1    = 7'h40;

  localparam int ACR_PB7_BIT     = 7;
  localparam int ACR_T1_FREE_BIT = 6;
  localparam int PCR_CA1_POS_BIT = 0;

  typedef logic [7:0] byte_t;
  typedef logic [15:0] count_t;
  typedef logic [6:0] irq_bits_t;

  // Port read: driven bits come from the output register, the rest from the pins.
  function automatic byte_t pin_mix(input byte_t outv, input byte_t dir, input byte_t pins);
    pin_mix = (outv & dir) | (pins & ~dir);
  endfunction

endpackage

### rtl/core/versatile_interface_adapter_top.sv
// Latency: a word's result is registered at the edge that accepts it and shows the next cycle.
// Throughput: one word per cycle while out_ready holds; every command is handled in a single pass of logic.
// in_ready stays high while the result register is empty or being drained.
// Reset (synchronous, rst_n low) clears every adapter register and the result valid; the result payload is not reset.
// All state changes take effect at the accepting edge, so the next word sees them at once.
`timescale 1ns / 1ps
`include "versatile_interface_adapter_top_assert.svh"
module versatile_interface_adapter_top
  import via_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  input  logic       in_ca1_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_out,
  output logic       out_pb7_toggle
);

  byte_t     out_a_r, out_b_r, dir_a_r, dir_b_r;
  byte_t     out_a_nxt, out_b_nxt, dir_a_nxt, dir_b_nxt;
  count_t    t1_count_r, t1_reload_r, t2_count_r;
  count_t    t1_count_nxt, t1_reload_nxt, t2_count_nxt;
  byte_t     t2_low_r, sr_r, acr_r, pcr_r;
  byte_t     t2_low_nxt, sr_nxt, acr_nxt, pcr_nxt;
  irq_bits_t flags_r, enables_r, flags_nxt, enables_nxt;
  logic      t1_active_r, t2_active_r, pb7_r, ca1_prev_r;
  logic      t1_active_nxt, t2_active_nxt, pb7_nxt, ca1_prev_nxt;
  logic      ca1_fired;

  byte_t     rd_data;
  logic      in_acc;
  logic      out_valid_r;
  byte_t     rd_data_r;
  logic      irq_r, pb7_out_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_read_data  = rd_data_r;
  assign out_irq_out    = irq_r;
  assign out_pb7_toggle = pb7_out_r;

  always_comb begin
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    dir_a_nxt     = dir_a_r;
    dir_b_nxt     = dir_b_r;
    t1_count_nxt  = t1_count_r;
    t1_reload_nxt = t1_reload_r;
    t2_count_nxt  = t2_count_r;
    t2_low_nxt    = t2_low_r;
    sr_nxt        = sr_r;
    acr_nxt       = acr_r;
    pcr_nxt       = pcr_r;
    flags_nxt     = flags_r;
    enables_nxt   = enables_r;
    t1_active_nxt = t1_active_r;
    t2_active_nxt = t2_active_r;
    pb7_nxt       = pb7_r;
    ca1_prev_nxt  = ca1_prev_r;
    rd_data       = 8'h00;
    ca1_fired     = 1'b0;

    case (in_cmd)
      CMD_READ: begin
        case (in_reg_index)
          REG_ORB:  rd_data = pin_mix(out_b_r, dir_b_r, in_port_b_pins);
          REG_ORA: begin
            rd_data   = pin_mix(out_a_r, dir_a_r, in_port_a_pins);
            flags_nxt = flags_r & ~FLAG_PORTA;
          end
          REG_DDRB: rd_data = dir_b_r;
          REG_DDRA: rd_data = dir_a_r;
          REG_T1CL: begin
            rd_data   = t1_count_r[7:0];
            flags_nxt = flags_r & ~FLAG_T1;
          end
          REG_T1CH: rd_data = t1_count_r[15:8];
          REG_T1LL: rd_data = t1_reload_r[7:0];
          REG_T1LH: rd_data = t1_reload_r[15:8];
          REG_T2CL: begin
            rd_data   = t2_count_r[7:0];
            flags_nxt = flags_r & ~FLAG_T2;
          end
          REG_T2CH: rd_data = t2_count_r[15:8];
          REG_SR:   rd_data = sr_r;
          REG_ACR:  rd_data = acr_r;
          REG_PCR:  rd_data = pcr_r;
          REG_IFR:  rd_data = {|(flags_r & enables_r), flags_r};
          REG_IER:  rd_data = {1'b1, enables_r};
          default:  rd_data = pin_mix(out_a_r, dir_a_r, in_port_a_pins);
        endcase
      end
      CMD_WRITE: begin
        case (in_reg_index)
          REG_ORB: out_b_nxt = in_write_data;
          REG_ORA: begin
            out_a_nxt = in_write_data;
            flags_nxt = flags_r & ~FLAG_PORTA;
          end
          REG_DDRB: dir_b_nxt = in_write_data;
          REG_DDRA: dir_a_nxt = in_write_data;
          REG_T1CL, REG_T1LL: t1_reload_nxt = {t1_reload_r[15:8], in_write_data};
          REG_T1CH: begin
            t1_reload_nxt = {in_write_data, t1_reload_r[7:0]};
            t1_count_nxt  = {in_write_data, t1_reload_r[7:0]};
            flags_nxt     = flags_r & ~FLAG_T1;
            t1_active_nxt = 1'b1;
          end
          REG_T1LH: t1_reload_nxt = {in_write_data, t1_reload_r[7:0]};
          REG_T2CL: t2_low_nxt = in_write_data;
          REG_T2CH: begin
            t2_count_nxt  = {in_write_data, t2_low_r};
            flags_nxt     = flags_r & ~FLAG_T2;
            t2_active_nxt = 1'b1;
          end
          REG_SR:  sr_nxt  = in_write_data;
          REG_ACR: acr_nxt = in_write_data;
          REG_PCR: pcr_nxt = in_write_data;
          REG_IFR: flags_nxt = flags_r & ~in_write_data[6:0];
          REG_IER: begin
            if (in_write_data[7]) begin
              enables_nxt = enables_r | in_write_data[6:0];
            end else begin
              enables_nxt = enables_r & ~in_write_data[6:0];
            end
          end
          default: out_a_nxt = in_write_data;
        endcase
      end
      CMD_TICK: begin
        // An active timer ticked at zero raises its flag, then reloads (timer 1 free-running) or stops.
        if (t1_active_r) begin
          t1_count_nxt = t1_count_r - 16'd1;
          if (t1_count_r == 16'h0000) begin
            flags_nxt = flags_nxt | FLAG_T1;
            if (acr_r[ACR_PB7_BIT]) begin
              pb7_nxt = !pb7_r;
            end
            if (acr_r[ACR_T1_FREE_BIT]) begin
              t1_count_nxt = t1_reload_r;
            end else begin
              t1_active_nxt = 1'b0;
            end
          end
        end
        if (t2_active_r) begin
          t2_count_nxt = t2_count_r - 16'd1;
          if (t2_count_r == 16'h0000) begin
            flags_nxt     = flags_nxt | FLAG_T2;
            t2_active_nxt = 1'b0;
          end
        end
      end
      default: begin
        if (pcr_r[PCR_CA1_POS_BIT]) begin
          ca1_fired = !ca1_prev_r && in_ca1_level;
        end else begin
          ca1_fired = ca1_prev_r && !in_ca1_level;
        end
        ca1_prev_nxt = in_ca1_level;
        if (ca1_fired) begin
          flags_nxt = flags_r | FLAG_CA1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_a_r     <= '0;
      out_b_r     <= '0;
      dir_a_r     <= '0;
      dir_b_r     <= '0;
      t1_count_r  <= '0;
      t1_reload_r <= '0;
      t2_count_r  <= '0;
      t2_low_r    <= '0;
      sr_r        <= '0;
      acr_r       <= '0;
      pcr_r       <= '0;
      flags_r     <= '0;
      enables_r   <= '0;
      t1_active_r <= 1'b0;
      t2_active_r <= 1'b0;
      pb7_r       <= 1'b0;
      ca1_prev_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        out_a_r     <= out_a_nxt;
        out_b_r     <= out_b_nxt;
        dir_a_r     <= dir_a_nxt;
        dir_b_r     <= dir_b_nxt;
        t1_count_r  <= t1_count_nxt;
        t1_reload_r <= t1_reload_nxt;
        t2_count_r  <= t2_count_nxt;
        t2_low_r    <= t2_low_nxt;
        sr_r        <= sr_nxt;
        acr_r       <= acr_nxt;
        pcr_r       <= pcr_nxt;
        flags_r     <= flags_nxt;
        enables_r   <= enables_nxt;
        t1_active_r <= t1_active_nxt;
        t2_active_r <= t2_active_nxt;
        pb7_r       <= pb7_nxt;
        ca1_prev_r  <= ca1_prev_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word payload; only loaded when a word is accepted.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= rd_data;
      irq_r     <= |(flags_nxt & enables_nxt);
      pb7_out_r <= pb7_nxt;
    end
  end

  `VIA_ASSERT_NEXT(a_nonread_zero, in_acc && (in_cmd != CMD_READ), out_read_data == 8'h00)
  `VIA_ASSERT_NOW(a_irq_tracks_state, out_valid_r, out_irq_out == |(flags_r & enables_r))
  `VIA_ASSERT_NOW(a_pb7_tracks_state, out_valid_r, out_pb7_toggle == pb7_r)
  `VIA_ASSERT_NEXT(a_t1_start, in_acc && (in_cmd == CMD_WRITE) && (in_reg_index == REG_T1CH), t1_active_r && !flags_r[6])
  `VIA_ASSERT_NEXT(a_t1_oneshot_stop, in_acc && (in_cmd == CMD_TICK) && t1_active_r && (t1_count_r == 16'h0000) && !acr_r[ACR_T1_FREE_BIT], !t1_active_r && (t1_count_r == 16'hFFFF))

endmodule

### dv/tb_versatile_interface_adapter_top.sv
// Self-checking testbench for the interface adapter: queued word driver, predictor and monitor.
`timescale 1ns / 1ps
module tb_versatile_interface_adapter_top
  import via_pkg::*;
;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca1_level;
  } adapter_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic       pb7_toggle;
  } adapter_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = CMD_READ;
  logic [3:0] in_reg_index = REG_ORB;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_port_a_pins = '0;
  logic [7:0] in_port_b_pins = '0;
  logic       in_ca1_level = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_out;
  logic       out_pb7_toggle;

  versatile_interface_adapter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .in_port_a_pins(in_port_a_pins),
    .in_port_b_pins(in_port_b_pins),
    .in_ca1_level  (in_ca1_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_irq_out   (out_irq_out),
    .out_pb7_toggle(out_pb7_toggle)
  );

  always #1 clk = ~clk;

  adapter_word_t  word_queue[$];
  adapter_reply_t expected_replies[$];
  int             words_accepted = 0;
  int             error_count = 0;
  logic           word_taken = 1'b0;
  logic           quiet;

  // Mirror of the adapter registers.
  byte_t     ora, orb, ddra, ddrb, sr_byte, acr, pcr, t2_latch_lo;
  count_t    t1_count, t1_reload, t2_count;
  irq_bits_t ifr, ier;
  logic      t1_active, t2_active, pb7, ca1_prev_lvl;

  // No idling on either side during this stretch of words.
  assign quiet = (words_accepted >= 800) && (words_accepted < 1100);

  function automatic adapter_reply_t execute_word(adapter_word_t w);
    adapter_reply_t r;
    logic           fired;
    r = '0;
    case (w.cmd)
      CMD_READ: begin
        case (w.reg_index)
          REG_ORB:  r.read_data = (orb & ddrb) | (w.port_b_pins & ~ddrb);
          REG_ORA: begin
            r.read_data = (ora & ddra) | (w.port_a_pins & ~ddra);
            ifr &= ~FLAG_PORTA;
          end
          REG_DDRB: r.read_data = ddrb;
          REG_DDRA: r.read_data = ddra;
          REG_T1CL: begin
            r.read_data = t1_count[7:0];
            ifr &= ~FLAG_T1;
          end
          REG_T1CH: r.read_data = t1_count[15:8];
          REG_T1LL: r.read_data = t1_reload[7:0];
          REG_T1LH: r.read_data = t1_reload[15:8];
          REG_T2CL: begin
            r.read_data = t2_count[7:0];
            ifr &= ~FLAG_T2;
          end
          REG_T2CH: r.read_data = t2_count[15:8];
          REG_SR:   r.read_data = sr_byte;
          REG_ACR:  r.read_data = acr;
          REG_PCR:  r.read_data = pcr;
          REG_IFR:  r.read_data = {|(ifr & ier), ifr};
          REG_IER:  r.read_data = {1'b1, ier};
          default:  r.read_data = (ora & ddra) | (w.port_a_pins & ~ddra);
        endcase
      end
      CMD_WRITE: begin
        case (w.reg_index)
          REG_ORB:  orb = w.write_data;
          REG_ORA: begin
            ora = w.write_data;
            ifr &= ~FLAG_PORTA;
          end
          REG_DDRB: ddrb = w.write_data;
          REG_DDRA: ddra = w.write_data;
          REG_T1CL, REG_T1LL: t1_reload[7:0] = w.write_data;
          REG_T1CH: begin
            t1_reload[15:8] = w.write_data;
            t1_count = t1_reload;
            ifr &= ~FLAG_T1;
            t1_active = 1'b1;
          end
          REG_T1LH: t1_reload[15:8] = w.write_data;
          REG_T2CL: t2_latch_lo = w.write_data;
          REG_T2CH: begin
            t2_count = {w.write_data, t2_latch_lo};
            ifr &= ~FLAG_T2;
            t2_active = 1'b1;
          end
          REG_SR:   sr_byte = w.write_data;
          REG_ACR:  acr = w.write_data;
          REG_PCR:  pcr = w.write_data;
          REG_IFR:  ifr &= ~w.write_data[6:0];
          REG_IER: begin
            if (w.write_data[7]) begin
              ier |= w.write_data[6:0];
            end else begin
              ier &= ~w.write_data[6:0];
            end
          end
          default:  ora = w.write_data;
        endcase
      end
      CMD_TICK: begin
        if (t1_active) begin
          t1_count = t1_count - 16'd1;
          if (t1_count == 16'hFFFF) begin
            ifr |= FLAG_T1;
            if (acr[ACR_PB7_BIT]) begin
              pb7 = ~pb7;
            end
            if (acr[ACR_T1_FREE_BIT]) begin
              t1_count = t1_reload;
            end else begin
              t1_active = 1'b0;
            end
          end
        end
        if (t2_active) begin
          t2_count = t2_count - 16'd1;
          if (t2_count == 16'hFFFF) begin
            ifr |= FLAG_T2;
            t2_active = 1'b0;
          end
        end
      end
      default: begin
        fired = pcr[PCR_CA1_POS_BIT] ? (!ca1_prev_lvl && w.ca1_level)
                                     : (ca1_prev_lvl && !w.ca1_level);
        ca1_prev_lvl = w.ca1_level;
        if (fired) begin
          ifr |= FLAG_CA1;
        end
      end
    endcase
    r.irq_out = |(ifr & ier);
    r.pb7_toggle = pb7;
    return r;
  endfunction

  function automatic void queue_word(logic [1:0] cmd, logic [3:0] idx, logic [7:0] data,
                                     logic lvl);
    adapter_word_t w;
    w.cmd = cmd;
    w.reg_index = idx;
    w.write_data = data;
    w.port_a_pins = 8'($urandom);
    w.port_b_pins = 8'($urandom);
    w.ca1_level = lvl;
    word_queue.push_back(w);
  endfunction

  function automatic logic [7:0] timer_low();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 12)) : 8'($urandom);
  endfunction

  function automatic logic [7:0] timer_high();
    return ($urandom_range(0, 9) < 8) ? 8'h00 : 8'($urandom);
  endfunction

  always @(negedge clk) begin : drive_words
    adapter_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (word_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 31)) begin
        nxt = word_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd <= nxt.cmd;
        in_reg_index <= nxt.reg_index;
        in_write_data <= nxt.write_data;
        in_port_a_pins <= nxt.port_a_pins;
        in_port_b_pins <= nxt.port_b_pins;
        in_ca1_level <= nxt.ca1_level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin : watch_replies
    adapter_word_t  w;
    adapter_reply_t exp_r;
    word_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("result word with no expectation pending");
        error_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_read_data !== exp_r.read_data) begin
          $error("read_data: expected %0h, actual %0h", exp_r.read_data, out_read_data);
          error_count++;
        end
        if (out_irq_out !== exp_r.irq_out) begin
          $error("irq_out: expected %0b, actual %0b", exp_r.irq_out, out_irq_out);
          error_count++;
        end
        if (out_pb7_toggle !== exp_r.pb7_toggle) begin
          $error("pb7_toggle: expected %0b, actual %0b", exp_r.pb7_toggle, out_pb7_toggle);
          error_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      w = {in_cmd, in_reg_index, in_write_data, in_port_a_pins, in_port_b_pins, in_ca1_level};
      expected_replies.push_back(execute_word(w));
      words_accepted++;
    end
  end

  initial begin : stimulus
    int pick;
    {ora, orb, ddra, ddrb, sr_byte, acr, pcr, t2_latch_lo} = '0;
    {t1_count, t1_reload, t2_count, ifr, ier} = '0;
    {t1_active, t2_active, pb7, ca1_prev_lvl} = '0;

    // Directed: port mixing, CA1 edge, free-running timer 1 with PB7, one-shot timer 2.
    queue_word(CMD_WRITE, REG_DDRA, 8'hF0, 1'b0);
    queue_word(CMD_WRITE, REG_ORA, 8'hAA, 1'b1);
    queue_word(CMD_READ, REG_ORA, 8'hFF, 1'b0);
    queue_word(CMD_WRITE, REG_DDRB, 8'hFF, 1'b1);
    queue_word(CMD_READ, REG_ORB, 8'h00, 1'b0);
    queue_word(CMD_WRITE, REG_IER, 8'hFF, 1'b0);
    queue_word(CMD_WRITE, REG_PCR, 8'h01, 1'b0);
    queue_word(CMD_CA1, REG_ORB, 8'h00, 1'b1);
    queue_word(CMD_READ, REG_IFR, 8'h00, 1'b0);
    queue_word(CMD_READ, REG_ORA_NH, 8'h00, 1'b0);
    queue_word(CMD_READ, REG_ORA, 8'h00, 1'b0);
    queue_word(CMD_WRITE, REG_ACR, 8'hC0, 1'b0);
    queue_word(CMD_WRITE, REG_T1CL, 8'h01, 1'b0);
    queue_word(CMD_WRITE, REG_T1CH, 8'h00, 1'b0);
    repeat (4) queue_word(CMD_TICK, REG_ORB, 8'h00, 1'b0);
    queue_word(CMD_READ, REG_T1CL, 8'h00, 1'b0);
    queue_word(CMD_WRITE, REG_T2CL, 8'h00, 1'b0);
    queue_word(CMD_WRITE, REG_T2CH, 8'h00, 1'b0);
    repeat (2) queue_word(CMD_TICK, REG_ORB, 8'h00, 1'b0);
    queue_word(CMD_READ, REG_T2CL, 8'h00, 1'b0);
    queue_word(CMD_WRITE, REG_IFR, 8'h7F, 1'b0);
    queue_word(CMD_READ, REG_IER, 8'h00, 1'b0);

    // Random: tick bursts and timer setups, plus CA1 events, reads and register writes.
    while (word_queue.size() < 1725) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        repeat ($urandom_range(1, 8)) begin
          queue_word(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
        end
      end else if (pick < 50) begin
        queue_word(CMD_WRITE, $urandom_range(0, 1) ? REG_T1CL : REG_T1LL, timer_low(),
                   1'($urandom));
        queue_word(CMD_WRITE, REG_T1CH, timer_high(), 1'($urandom));
      end else if (pick < 58) begin
        queue_word(CMD_WRITE, REG_T2CL, timer_low(), 1'($urandom));
        queue_word(CMD_WRITE, REG_T2CH, timer_high(), 1'($urandom));
      end else if (pick < 66) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_word(CMD_WRITE, REG_PCR, 8'($urandom), 1'($urandom));
        end
        queue_word(CMD_CA1, 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        queue_word(CMD_READ, 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 86) begin
        queue_word(CMD_WRITE, REG_ACR, 8'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        queue_word(CMD_WRITE, REG_IER, 8'($urandom), 1'($urandom));
      end else if (pick < 94) begin
        queue_word(CMD_WRITE, REG_IFR, 8'($urandom), 1'($urandom));
      end else begin
        queue_word(CMD_WRITE, 4'($urandom), 8'($urandom), 1'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
